[rtl/pdrc_pkg.sv]
// Shared constants, types and codes for the route checker.
`timescale 1ns / 1ps

package pdrc_pkg;

    // Geometry and time widths
    localparam int COORD_BITS = 12;
    localparam int TIME_BITS  = 32;

    // Fixed field widths
    localparam int CAP_BITS    = 16;
    localparam int DEM_BITS    = 11;
    localparam int WIN_BITS    = 20;
    localparam int SERV_BITS   = 16;
    localparam int OUT_T_BITS  = 32;
    localparam int LOAD_BITS   = 24;
    localparam int PADDR_BITS  = 4;
    localparam int PDATA_BITS  = 32;

    // Scale factors: travel is isqrt(d^2 * 10000), times are kept in hundredths
    localparam int HUND       = 100;
    localparam int DIST_SCALE = 10000;

    // Derived widths
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int RAD_BITS    = 2 * COORD_BITS + 15;
    localparam int ISQ_STEPS   = (RAD_BITS + 1) / 2;
    localparam int ROOT_BITS   = ISQ_STEPS;
    localparam int HUND_BITS   = 27;
    localparam int SERV_H_BITS = 23;
    localparam int ARR_BITS    = (TIME_BITS > HUND_BITS) ? TIME_BITS : HUND_BITS;
    localparam int SUM_BITS    = ((ARR_BITS > OUT_T_BITS) ? ARR_BITS : OUT_T_BITS) + 2;

    // Route checking queue
    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = 1;
    localparam int QCNT_BITS = 2;

    // Register map indexes
    localparam logic [1:0] REG_CAPACITY  = 2'd0;
    localparam logic [1:0] REG_DEPOT_X   = 2'd1;
    localparam logic [1:0] REG_DEPOT_Y   = 2'd2;
    localparam logic [1:0] REG_DEPOT_DUE = 2'd3;

    // Failure reasons
    localparam logic [1:0] REASON_NONE   = 2'd0;
    localparam logic [1:0] REASON_LOAD   = 2'd1;
    localparam logic [1:0] REASON_WINDOW = 2'd2;
    localparam logic [1:0] REASON_DEPOT  = 2'd3;

    // One classified stop, handed from the front to the back
    typedef struct packed {
        logic [RAD_BITS-1:0]    rad_in;
        logic [RAD_BITS-1:0]    rad_ret;
        logic signed [DEM_BITS-1:0] demand;
        logic [HUND_BITS-1:0]   ready_h;
        logic [HUND_BITS-1:0]   due_h;
        logic [SERV_H_BITS-1:0] serv_h;
        logic                   last;
    } pdrc_job_t;

endpackage

[rtl/pdrc_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module pdrc_isqrt
    import pdrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RAD_BITS-1:0]  radicand,
    output logic                 done,
    output logic [ROOT_BITS-1:0] root
);

    localparam logic [RAD_BITS:0] TOP_BIT = (RAD_BITS+1)'(1) << (2 * (ISQ_STEPS - 1));

    logic                busy_reg;
    logic                done_reg;
    logic [RAD_BITS-1:0] v_reg;
    logic [RAD_BITS:0]   root_reg;
    logic [RAD_BITS:0]   bit_reg;
    logic [RAD_BITS+1:0] trial;
    logic                take;

    assign trial = (RAD_BITS+2)'(root_reg) + (RAD_BITS+2)'(bit_reg);
    assign take  = (RAD_BITS+2)'(v_reg) >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && bit_reg[0];
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg[0])
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= radicand;
            root_reg <= '0;
            bit_reg  <= TOP_BIT;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                v_reg    <= v_reg - trial[RAD_BITS-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = root_reg[ROOT_BITS-1:0];

endmodule

[rtl/pdrc_front.sv]
// Front end: accept a stop, form squared distances and scaled times.
`timescale 1ns / 1ps

module pdrc_front
    import pdrc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] stop_x,
    input  logic [COORD_BITS-1:0] stop_y,
    input  logic signed [DEM_BITS-1:0] demand,
    input  logic [WIN_BITS-1:0]   ready_time,
    input  logic [WIN_BITS-1:0]   due_time,
    input  logic [SERV_BITS-1:0]  service_time,
    input  logic                  last_stop,
    input  logic [COORD_BITS-1:0] depot_x,
    input  logic [COORD_BITS-1:0] depot_y,
    input  logic                  full,
    output logic                  push,
    output pdrc_job_t             job
);

    typedef enum logic [3:0] {
        F_IDLE   = 4'b0001,
        F_SQUARE = 4'b0010,
        F_SCALE  = 4'b0100,
        F_PUSH   = 4'b1000
    } front_state_t;

    function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                       input logic [COORD_BITS-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    front_state_t state_reg, state_next;
    logic [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic                  first_reg;
    logic                  accept;
    logic [COORD_BITS-1:0] from_x, from_y;

    logic [COORD_BITS-1:0] dxi_reg, dyi_reg, dxr_reg, dyr_reg;
    logic [SQ_BITS-1:0]    sxi_reg, syi_reg, sxr_reg, syr_reg;
    logic signed [DEM_BITS-1:0] demand_reg;
    logic [WIN_BITS-1:0]   ready_reg, due_reg;
    logic [SERV_BITS-1:0]  serv_reg;
    logic                  last_reg;
    pdrc_job_t             job_reg;

    assign accept   = in_valid && (state_reg == F_IDLE);
    assign in_stall = (state_reg != F_IDLE);
    assign push     = (state_reg == F_PUSH) && !full;
    assign job      = job_reg;

    // The first stop of a route is reached from the depot
    assign from_x = first_reg ? depot_x : prev_x_reg;
    assign from_y = first_reg ? depot_y : prev_y_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:   if (in_valid) state_next = F_SQUARE;
            F_SQUARE: state_next = F_SCALE;
            F_SCALE:  state_next = F_PUSH;
            F_PUSH:   if (!full) state_next = F_IDLE;
            default:  state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            first_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                prev_x_reg <= stop_x;
                prev_y_reg <= stop_y;
                first_reg  <= last_stop;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dxi_reg    <= abs_diff(stop_x, from_x);
            dyi_reg    <= abs_diff(stop_y, from_y);
            dxr_reg    <= abs_diff(stop_x, depot_x);
            dyr_reg    <= abs_diff(stop_y, depot_y);
            demand_reg <= demand;
            ready_reg  <= ready_time;
            due_reg    <= due_time;
            serv_reg   <= service_time;
            last_reg   <= last_stop;
        end
        if (state_reg == F_SQUARE)
        begin
            sxi_reg        <= SQ_BITS'(dxi_reg) * SQ_BITS'(dxi_reg);
            syi_reg        <= SQ_BITS'(dyi_reg) * SQ_BITS'(dyi_reg);
            sxr_reg        <= SQ_BITS'(dxr_reg) * SQ_BITS'(dxr_reg);
            syr_reg        <= SQ_BITS'(dyr_reg) * SQ_BITS'(dyr_reg);
            job_reg.ready_h <= HUND_BITS'(ready_reg) * HUND_BITS'(HUND);
            job_reg.due_h   <= HUND_BITS'(due_reg) * HUND_BITS'(HUND);
            job_reg.serv_h  <= SERV_H_BITS'(serv_reg) * SERV_H_BITS'(HUND);
            job_reg.demand  <= demand_reg;
            job_reg.last    <= last_reg;
        end
        if (state_reg == F_SCALE)
        begin
            job_reg.rad_in  <= RAD_BITS'((SQ_BITS+1)'(sxi_reg) + (SQ_BITS+1)'(syi_reg))
                               * RAD_BITS'(DIST_SCALE);
            job_reg.rad_ret <= RAD_BITS'((SQ_BITS+1)'(sxr_reg) + (SQ_BITS+1)'(syr_reg))
                               * RAD_BITS'(DIST_SCALE);
        end
    end

endmodule

[rtl/pdrc_queue.sv]
// Two-entry queue of classified stops between front and back.
`timescale 1ns / 1ps

module pdrc_queue
    import pdrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pdrc_job_t push_data,
    output logic      full,
    input  logic      pop,
    output pdrc_job_t pop_data,
    output logic      empty
);

    pdrc_job_t             mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0]  count_reg, count_next;

    assign full     = (count_reg == QCNT_BITS'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/pdrc_back.sv]
// Back end: run travel roots, keep load and time, issue the verdict.
`timescale 1ns / 1ps

module pdrc_back
    import pdrc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   empty,
    output logic                   pop,
    input  pdrc_job_t              head,
    input  logic [CAP_BITS-1:0]    capacity,
    input  logic [HUND_BITS-1:0]   depot_due_h,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   feasible,
    output logic [1:0]             fail_reason,
    output logic [OUT_T_BITS-1:0]  return_time
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_ROOT = 4'b0010,
        B_ACC  = 4'b0100,
        B_RET  = 4'b1000
    } back_state_t;

    localparam logic signed [LOAD_BITS:0] LOAD_HI =
        (LOAD_BITS+1)'((1 << (LOAD_BITS - 1)) - 1);
    localparam logic signed [LOAD_BITS:0] LOAD_LO = -LOAD_HI - (LOAD_BITS+1)'(1);
    localparam logic [SUM_BITS-1:0] TIME_MAX_S = (SUM_BITS'(1) << TIME_BITS) - SUM_BITS'(1);
    localparam logic [SUM_BITS-1:0] OUT_MAX_S  =
        (SUM_BITS'(1) << OUT_T_BITS) - SUM_BITS'(1);

    back_state_t state_reg, state_next;
    logic        ret_phase_reg;
    pdrc_job_t   job_reg;

    logic signed [LOAD_BITS-1:0] load_reg;
    logic                        load_failed_reg;
    logic                        window_failed_reg;
    logic [ARR_BITS-1:0]         arrival_reg;
    logic [SERV_H_BITS-1:0]      prev_serv_h_reg;

    logic                  out_valid_reg;
    logic                  feasible_reg;
    logic [1:0]            reason_reg;
    logic [OUT_T_BITS-1:0] return_time_reg;

    logic                  sq_start;
    logic [RAD_BITS-1:0]   sq_rad;
    logic                  sq_done;
    logic [ROOT_BITS-1:0]  sq_root;

    logic signed [LOAD_BITS:0]   load_sum;
    logic signed [LOAD_BITS-1:0] load_new;
    logic signed [LOAD_BITS-1:0] cap_s;

    logic [SUM_BITS-1:0] arr_sum, ret_sum, ret_sat;
    logic [ARR_BITS-1:0] arr_sat, arr_new;
    logic [1:0]          reason_new;
    logic                out_free;
    logic                deliver;

    pdrc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign pop      = (state_reg == B_IDLE) && !empty;
    assign out_free = !out_valid_reg || !out_stall;
    assign deliver  = (state_reg == B_RET) && out_free;

    // Inbound leg starts on pop, return leg after the last stop's time update
    assign sq_start = pop || ((state_reg == B_ACC) && job_reg.last);
    assign sq_rad   = pop ? head.rad_in : job_reg.rad_ret;

    // Saturating running load
    always_comb
    begin
        load_sum = (LOAD_BITS+1)'(load_reg) + (LOAD_BITS+1)'($signed(head.demand));
        if (load_sum > LOAD_HI)
            load_new = LOAD_HI[LOAD_BITS-1:0];
        else if (load_sum < LOAD_LO)
            load_new = LOAD_LO[LOAD_BITS-1:0];
        else
            load_new = load_sum[LOAD_BITS-1:0];
    end

    assign cap_s = $signed(LOAD_BITS'(capacity));

    // Service start at this stop
    always_comb
    begin
        arr_sum = SUM_BITS'(arrival_reg) + SUM_BITS'(prev_serv_h_reg) + SUM_BITS'(sq_root);
        arr_sat = (arr_sum > TIME_MAX_S) ? ARR_BITS'(TIME_MAX_S) : arr_sum[ARR_BITS-1:0];
        arr_new = (arr_sat < ARR_BITS'(job_reg.ready_h)) ? ARR_BITS'(job_reg.ready_h)
                                                         : arr_sat;
    end

    // Return to the depot and verdict
    always_comb
    begin
        ret_sum = SUM_BITS'(arrival_reg) + SUM_BITS'(job_reg.serv_h) + SUM_BITS'(sq_root);
        ret_sat = (ret_sum > TIME_MAX_S) ? TIME_MAX_S : ret_sum;
        if (load_failed_reg)
            reason_new = REASON_LOAD;
        else if (window_failed_reg)
            reason_new = REASON_WINDOW;
        else if (ret_sat > SUM_BITS'(depot_due_h))
            reason_new = REASON_DEPOT;
        else
            reason_new = REASON_NONE;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (!empty) state_next = B_ROOT;
            B_ROOT:
            begin
                if (sq_done)
                    state_next = ret_phase_reg ? B_RET : B_ACC;
            end
            B_ACC:  state_next = job_reg.last ? B_ROOT : B_IDLE;
            B_RET:  if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= B_IDLE;
            ret_phase_reg     <= 1'b0;
            load_reg          <= '0;
            load_failed_reg   <= 1'b0;
            window_failed_reg <= 1'b0;
            arrival_reg       <= '0;
            prev_serv_h_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                ret_phase_reg <= 1'b0;
                load_reg      <= load_new;
                if (load_new > cap_s)
                    load_failed_reg <= 1'b1;
            end
            if (state_reg == B_ACC)
            begin
                ret_phase_reg   <= 1'b1;
                arrival_reg     <= arr_new;
                prev_serv_h_reg <= job_reg.serv_h;
                if (arr_new > ARR_BITS'(job_reg.due_h))
                    window_failed_reg <= 1'b1;
            end
            // Drop route state once the verdict is handed over
            if (deliver)
            begin
                load_reg          <= '0;
                load_failed_reg   <= 1'b0;
                window_failed_reg <= 1'b0;
                arrival_reg       <= '0;
                prev_serv_h_reg   <= '0;
            end
            if (deliver)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head;
        if (deliver)
        begin
            feasible_reg    <= (reason_new == REASON_NONE);
            reason_reg      <= reason_new;
            return_time_reg <= (ret_sat > OUT_MAX_S) ? OUT_T_BITS'(OUT_MAX_S)
                                                     : ret_sat[OUT_T_BITS-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign feasible    = feasible_reg;
    assign fail_reason = reason_reg;
    assign return_time = return_time_reg;

endmodule

[rtl/pickup_delivery_route_checker_unit.sv]
// Top level of the pickup and delivery route checker with its register port.
//
//  channel  direction  handshake              payload
//  stop     in         in_valid / in_stall    stop_x .. last_stop
//  verdict  out        out_valid / out_stall  feasible, fail_reason, return_time
//  config   in         psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// The front takes one stop at a time through its square, scale and push steps
// and hands it to a two-deep queue. The back takes each stop through root and
// accumulate steps, and runs one more root on the last stop for the return leg;
// the bit-serial square root unit sets the rate, one root bit per cycle.
// Reset clears the route state and loads the register defaults; no clearing
// pass is needed. A stalled verdict holds the back in its final step, the
// queue then fills and in_stall rises while the front waits to push.
`timescale 1ns / 1ps

module pickup_delivery_route_checker_unit
    import pdrc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    // Stop input
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] stop_x,
    input  logic [COORD_BITS-1:0] stop_y,
    input  logic signed [DEM_BITS-1:0] demand,
    input  logic [WIN_BITS-1:0]   ready_time,
    input  logic [WIN_BITS-1:0]   due_time,
    input  logic [SERV_BITS-1:0]  service_time,
    input  logic                  last_stop,
    // Verdict output
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  feasible,
    output logic [1:0]            fail_reason,
    output logic [OUT_T_BITS-1:0] return_time
);

    logic [CAP_BITS-1:0]   capacity_reg;
    logic [COORD_BITS-1:0] depot_x_reg;
    logic [COORD_BITS-1:0] depot_y_reg;
    logic [WIN_BITS-1:0]   depot_due_reg;
    logic [HUND_BITS-1:0]  depot_due_h_reg;

    logic      cfg_write;
    logic [1:0] reg_index;

    logic      q_push, q_full, q_pop, q_empty;
    pdrc_job_t q_in, q_head;

    // Register port: every access completes in its access cycle
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_BITS'(200);
            depot_x_reg   <= '0;
            depot_y_reg   <= '0;
            depot_due_reg <= WIN_BITS'(1000000);
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_CAPACITY:  capacity_reg  <= pwdata[CAP_BITS-1:0];
                REG_DEPOT_X:   depot_x_reg   <= pwdata[COORD_BITS-1:0];
                REG_DEPOT_Y:   depot_y_reg   <= pwdata[COORD_BITS-1:0];
                REG_DEPOT_DUE: depot_due_reg <= pwdata[WIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_CAPACITY:  prdata = PDATA_BITS'(capacity_reg);
            REG_DEPOT_X:   prdata = PDATA_BITS'(depot_x_reg);
            REG_DEPOT_Y:   prdata = PDATA_BITS'(depot_y_reg);
            REG_DEPOT_DUE: prdata = PDATA_BITS'(depot_due_reg);
            default:       prdata = '0;
        endcase
    end

    // Depot deadline in hundredths; settles in the cycle after a write, long
    // before any route can reach its verdict
    always_ff @(posedge clk)
    begin
        depot_due_h_reg <= HUND_BITS'(depot_due_reg) * HUND_BITS'(HUND);
    end

    pdrc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .stop_x       (stop_x),
        .stop_y       (stop_y),
        .demand       (demand),
        .ready_time   (ready_time),
        .due_time     (due_time),
        .service_time (service_time),
        .last_stop    (last_stop),
        .depot_x      (depot_x_reg),
        .depot_y      (depot_y_reg),
        .full         (q_full),
        .push         (q_push),
        .job          (q_in)
    );

    pdrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head),
        .empty     (q_empty)
    );

    pdrc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (q_empty),
        .pop         (q_pop),
        .head        (q_head),
        .capacity    (capacity_reg),
        .depot_due_h (depot_due_h_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .feasible    (feasible),
        .fail_reason (fail_reason),
        .return_time (return_time)
    );

`ifndef SYNTHESIS
    // Front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
        else $error("queue push while full");

    // Back never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && q_empty))
        else $error("queue pop while empty");

    // A transfer into the front makes it busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (in_valid && !in_stall) |=> in_stall)
        else $error("front took a second stop while busy");

    // The verdict flag agrees with the reason code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (feasible == (fail_reason == REASON_NONE)))
        else $error("feasible flag disagrees with reason");
`endif

endmodule
